FILE: src/ewad_pkg.sv
`default_nettype none

package ewad_pkg;

   localparam int AddrWidth   = 16;
   localparam int DataWidth   = 8;
   localparam int OffsetWidth = 11;
   localparam int RegionWidth = 4;
   localparam int ChipWidth   = 3;

   localparam logic [DataWidth-1:0] OPC_STORE = 8'h32;

   // chip type register codes
   localparam logic [ChipWidth-1:0] CHIP_NONE = 3'd0;
   localparam logic [ChipWidth-1:0] CHIP_62   = 3'd1;
   localparam logic [ChipWidth-1:0] CHIP_63   = 3'd2;
   localparam logic [ChipWidth-1:0] CHIP_64   = 3'd3;
   localparam logic [ChipWidth-1:0] CHIP_70   = 3'd4;
   localparam logic [ChipWidth-1:0] CHIP_76   = 3'd5;
   localparam logic [ChipWidth-1:0] CHIP_82   = 3'd6;

   typedef enum logic [RegionWidth-1:0] {
      REGION_ROM      = 4'd0,
      REGION_MISC1    = 4'd1,
      REGION_VIDEO    = 4'd2,
      REGION_BRAM     = 4'd3,
      REGION_CHAR     = 4'd4,
      REGION_COLOR    = 4'd5,
      REGION_BCOLOR   = 4'd6,
      REGION_MISC2    = 4'd7,
      REGION_CHAR2    = 4'd8,
      REGION_UNMAPPED = 4'd9
   } region_type;

   typedef enum logic [1:0] {
      PERM_A = 2'd0,
      PERM_B = 2'd1,
      PERM_C = 2'd2,
      PERM_D = 2'd3
   } perm_type;

   // region base addresses
   localparam logic [AddrWidth-1:0] BASE_MISC1  = 16'hC800;
   localparam logic [AddrWidth-1:0] BASE_HOLE   = 16'hD000;
   localparam logic [AddrWidth-1:0] BASE_VIDEO  = 16'hE000;
   localparam logic [AddrWidth-1:0] BASE_BRAM   = 16'hE400;
   localparam logic [AddrWidth-1:0] BASE_CHAR   = 16'hE800;
   localparam logic [AddrWidth-1:0] BASE_COLOR  = 16'hF000;
   localparam logic [AddrWidth-1:0] BASE_BCOLOR = 16'hF040;
   localparam logic [AddrWidth-1:0] BASE_MISC2  = 16'hF080;
   localparam logic [AddrWidth-1:0] BASE_CHAR2  = 16'hF800;

   function automatic logic [DataWidth-1:0] perm_b(input logic [DataWidth-1:0] b);
      return {b[2], b[7], b[3], ~b[4], b[6], b[5], b[1], b[0]};
   endfunction

   function automatic logic [DataWidth-1:0] perm_c(input logic [DataWidth-1:0] b);
      return {b[2], b[3], ~b[6], b[5], b[7], b[4], b[1], b[0]};
   endfunction

   function automatic logic [DataWidth-1:0] perm_d(input logic [DataWidth-1:0] b);
      return {~b[2], b[4], b[5], b[3], b[7], b[6], b[1], b[0]};
   endfunction

   // pick the permutation from the chip type and two fetch address bits
   function automatic perm_type select_perm(input logic [ChipWidth-1:0] chip,
                                            input logic [AddrWidth-1:0] fa);
      perm_type p;
      p = PERM_A;
      unique case (chip)
         CHIP_62: begin
            unique case ({fa[1], fa[0]})
               2'd0: p = PERM_D;
               2'd1: p = PERM_C;
               2'd2: p = PERM_B;
               default: p = PERM_A;
            endcase
         end
         CHIP_63: begin
            unique case ({fa[3], fa[0]})
               2'd0: p = PERM_D;
               2'd1: p = PERM_C;
               2'd2: p = PERM_B;
               default: p = PERM_A;
            endcase
         end
         CHIP_64: p = perm_type'({fa[1], fa[0]});
         CHIP_70: begin
            unique case ({fa[3], fa[0]})
               2'd0: p = PERM_B;
               2'd1: p = PERM_A;
               2'd2: p = PERM_D;
               default: p = PERM_C;
            endcase
         end
         CHIP_76: p = perm_type'({fa[3], fa[0]});
         CHIP_82: p = perm_type'({fa[4], fa[0]});
         default: p = PERM_A;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: src/ewad_if.sv
`default_nettype none

interface ewad_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic [15:0] fetch_address;
   logic        fetch_valid;
   logic [7:0]  fetch_opcode;

   modport source (
      output valid, write_address, write_data, fetch_address, fetch_valid, fetch_opcode,
      input  ready
   );
   modport sink (
      input  valid, write_address, write_data, fetch_address, fetch_valid, fetch_opcode,
      output ready
   );
endinterface

interface ewad_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] decoded_address;
   logic [3:0]  target_region;
   logic [10:0] region_offset;
   logic [7:0]  data_out;

   modport source (
      output valid, decoded_address, target_region, region_offset, data_out,
      input  ready
   );
   modport sink (
      input  valid, decoded_address, target_region, region_offset, data_out,
      output ready
   );
endinterface

`default_nettype wire

FILE: src/encrypted_write_address_decoder_core.sv
`default_nettype none

// channel   dir   handshake        word
// req       in    valid/ready      write address, data, fetch address/valid/opcode
// rsp       out   valid/ready      decoded address, region, offset, data
// csr       in    write enable     chip type (3 bits)
//
// one word per cycle sustained while rsp is taken; rsp valid rises when an accepted word moves
// from the input register into the result register, through the decode logic between them.
// reset clears both stage valids and sets chip type to none.
// a stalled rsp holds its word; the input register still takes a word while
// the result register is waiting, then req stalls until rsp is taken.

module encrypted_write_address_decoder_core (
   input  wire logic clock,
   input  wire logic reset,
   ewad_req_if.sink   req,
   ewad_rsp_if.source rsp,
   input  wire logic                          csr_write_enable,
   input  wire logic [ewad_pkg::ChipWidth-1:0] csr_write_data
);
   import ewad_pkg::*;

   logic [ChipWidth-1:0]   chip_ff, chip_in;

   // input register
   logic                   s1_valid_ff, s1_valid_in;
   logic [AddrWidth-1:0]   s1_addr_ff, s1_addr_in;
   logic [DataWidth-1:0]   s1_data_ff, s1_data_in;
   logic [AddrWidth-1:0]   s1_fa_ff, s1_fa_in;
   logic                   s1_fv_ff, s1_fv_in;
   logic [DataWidth-1:0]   s1_op_ff, s1_op_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AddrWidth-1:0]   rsp_addr_ff, rsp_addr_in;
   region_type             rsp_region_ff, rsp_region_in;
   logic [OffsetWidth-1:0] rsp_offset_ff, rsp_offset_in;
   logic [DataWidth-1:0]   rsp_data_ff, rsp_data_in;

   logic                   s1_advance;
   logic                   req_take;
   logic [DataWidth-1:0]   low_byte;
   logic [AddrWidth-1:0]   dec_addr;
   logic [AddrWidth-1:0]   base;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req.valid && req.ready;

   assign chip_in = csr_write_enable ? csr_write_data : chip_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_addr_in  = s1_addr_ff;
      s1_data_in  = s1_data_ff;
      s1_fa_in    = s1_fa_ff;
      s1_fv_in    = s1_fv_ff;
      s1_op_in    = s1_op_ff;
      if (req.ready) begin
         s1_valid_in = req.valid;
      end
      if (req_take) begin
         s1_addr_in = req.write_address;
         s1_data_in = req.write_data;
         s1_fa_in   = req.fetch_address;
         s1_fv_in   = req.fetch_valid;
         s1_op_in   = req.fetch_opcode;
      end
   end

   // low byte scramble
   always_comb begin
      low_byte = s1_addr_ff[DataWidth-1:0];
      if (s1_fv_ff && (s1_op_ff == OPC_STORE)) begin
         case (select_perm(chip_ff, s1_fa_ff))
            PERM_B:  low_byte = perm_b(s1_addr_ff[DataWidth-1:0]);
            PERM_C:  low_byte = perm_c(s1_addr_ff[DataWidth-1:0]);
            PERM_D:  low_byte = perm_d(s1_addr_ff[DataWidth-1:0]);
            default: low_byte = s1_addr_ff[DataWidth-1:0];
         endcase
      end
   end

   assign dec_addr = {s1_addr_ff[AddrWidth-1:DataWidth], low_byte};

   // region decode
   always_comb begin
      rsp_region_in = REGION_CHAR2;
      base          = BASE_CHAR2;
      if (dec_addr < BASE_MISC1) begin
         rsp_region_in = REGION_ROM;
         base          = dec_addr;
      end else if (dec_addr < BASE_HOLE) begin
         rsp_region_in = REGION_MISC1;
         base          = BASE_MISC1;
      end else if (dec_addr < BASE_VIDEO) begin
         rsp_region_in = REGION_UNMAPPED;
         base          = dec_addr;
      end else if (dec_addr < BASE_BRAM) begin
         rsp_region_in = REGION_VIDEO;
         base          = BASE_VIDEO;
      end else if (dec_addr < BASE_CHAR) begin
         rsp_region_in = REGION_BRAM;
         base          = BASE_BRAM;
      end else if (dec_addr < BASE_COLOR) begin
         rsp_region_in = REGION_CHAR;
         base          = BASE_CHAR;
      end else if (dec_addr < BASE_BCOLOR) begin
         rsp_region_in = REGION_COLOR;
         base          = BASE_COLOR;
      end else if (dec_addr < BASE_MISC2) begin
         rsp_region_in = REGION_BCOLOR;
         base          = BASE_BCOLOR;
      end else if (dec_addr < BASE_CHAR2) begin
         rsp_region_in = REGION_MISC2;
         base          = BASE_MISC2;
      end
   end

   // rom and unmapped use the address itself as base, giving a zero offset
   always_comb begin
      logic [AddrWidth-1:0] diff;
      diff          = dec_addr - base;
      rsp_offset_in = diff[OffsetWidth-1:0];
   end

   assign rsp_addr_in  = dec_addr;
   assign rsp_data_in  = s1_data_ff;
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff      <= CHIP_NONE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chip_ff      <= chip_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= s1_addr_in;
      s1_data_ff <= s1_data_in;
      s1_fa_ff   <= s1_fa_in;
      s1_fv_ff   <= s1_fv_in;
      s1_op_ff   <= s1_op_in;
      if (s1_advance) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_region_ff <= rsp_region_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.decoded_address = rsp_addr_ff;
   assign rsp.target_region   = rsp_region_ff;
   assign rsp.region_offset   = rsp_offset_ff;
   assign rsp.data_out        = rsp_data_ff;

endmodule

`default_nettype wire

FILE: verif/encrypted_write_address_decoder_core_tb.sv
`default_nettype none

module encrypted_write_address_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ewad_pkg::*;

   localparam int HalfPeriod    = 4;
   localparam int ResetCycles   = 6;
   localparam int Phases        = 12;
   localparam int PhaseWords    = 150;
   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 3000;

   localparam logic [ChipWidth-1:0] CHIP_UNUSED = 3'd7;
   localparam logic [DataWidth-1:0] OPC_OTHER   = 8'h33;

   localparam logic [ChipWidth-1:0] CHIP_PLAN [Phases] = '{
      CHIP_NONE, CHIP_62, CHIP_63, CHIP_64, CHIP_70, CHIP_76,
      CHIP_82, CHIP_UNUSED, CHIP_NONE, CHIP_62, CHIP_82, CHIP_UNUSED
   };

   // first and last address of every region
   localparam logic [AddrWidth-1:0] REGION_EDGES [20] = '{
      16'h0000, 16'hC7FF, 16'hC800, 16'hCFFF, 16'hD000, 16'hDFFF, 16'hE000,
      16'hE3FF, 16'hE400, 16'hE7FF, 16'hE800, 16'hEFFF, 16'hF000, 16'hF03F,
      16'hF040, 16'hF07F, 16'hF080, 16'hF7FF, 16'hF800, 16'hFFFF
   };

   // high bytes that sit on a region edge
   localparam logic [7:0] EDGE_PAGES [16] = '{
      8'h00, 8'hC7, 8'hC8, 8'hCF, 8'hD0, 8'hDF, 8'hE0, 8'hE3,
      8'hE4, 8'hE7, 8'hE8, 8'hEF, 8'hF0, 8'hF7, 8'hF8, 8'hFF
   };

   typedef struct packed {
      logic [AddrWidth-1:0] write_address;
      logic [DataWidth-1:0] write_data;
      logic [AddrWidth-1:0] fetch_address;
      logic                 fetch_valid;
      logic [DataWidth-1:0] fetch_opcode;
   } write_type;

   typedef struct packed {
      logic [AddrWidth-1:0]   decoded_address;
      region_type             target_region;
      logic [OffsetWidth-1:0] region_offset;
      logic [DataWidth-1:0]   data_out;
   } decode_type;

   class decode_checker;
      logic [ChipWidth-1:0] chip;
      decode_type           due_decodes[$];
      int unsigned          errors;

      function new();
         chip   = CHIP_NONE;
         errors = 0;
      endfunction

      function void set_chip(logic [ChipWidth-1:0] c);
         chip = c;
      endfunction

      function logic [7:0] scramble_low(logic [AddrWidth-1:0] fa, logic [7:0] b);
         logic [1:0] s;
         perm_type   p;
         logic [7:0] r;
         case (chip)
            CHIP_62, CHIP_64: s = {fa[1], fa[0]};
            CHIP_82:          s = {fa[4], fa[0]};
            default:          s = {fa[3], fa[0]};
         endcase
         case (chip)
            CHIP_62, CHIP_63:          p = perm_type'(~s);
            CHIP_70:                   p = perm_type'(s ^ 2'b01);
            CHIP_64, CHIP_76, CHIP_82: p = perm_type'(s);
            default:                   p = PERM_A;
         endcase
         r = b;
         case (p)
            PERM_B: begin
               r[7] = b[2];
               r[6] = b[7];
               r[5] = b[3];
               r[4] = ~b[4];
               r[3] = b[6];
               r[2] = b[5];
            end
            PERM_C: begin
               r[7] = b[2];
               r[6] = b[3];
               r[5] = ~b[6];
               r[4] = b[5];
               r[3] = b[7];
               r[2] = b[4];
            end
            PERM_D: begin
               r[7] = ~b[2];
               r[6] = b[4];
               r[4] = b[3];
               r[3] = b[7];
               r[2] = b[6];
            end
            default: r = b;
         endcase
         return r;
      endfunction

      function decode_type predict_decode(write_type w);
         decode_type           d;
         logic [AddrWidth-1:0] a;
         logic [AddrWidth-1:0] base;
         a    = w.write_address;
         base = '0;
         if (w.fetch_valid && w.fetch_opcode == OPC_STORE)
            a[7:0] = scramble_low(w.fetch_address, a[7:0]);
         if (a < BASE_MISC1)       d.target_region = REGION_ROM;
         else if (a < BASE_HOLE)   begin d.target_region = REGION_MISC1;  base = BASE_MISC1;  end
         else if (a < BASE_VIDEO)  d.target_region = REGION_UNMAPPED;
         else if (a < BASE_BRAM)   begin d.target_region = REGION_VIDEO;  base = BASE_VIDEO;  end
         else if (a < BASE_CHAR)   begin d.target_region = REGION_BRAM;   base = BASE_BRAM;   end
         else if (a < BASE_COLOR)  begin d.target_region = REGION_CHAR;   base = BASE_CHAR;   end
         else if (a < BASE_BCOLOR) begin d.target_region = REGION_COLOR;  base = BASE_COLOR;  end
         else if (a < BASE_MISC2)  begin d.target_region = REGION_BCOLOR; base = BASE_BCOLOR; end
         else if (a < BASE_CHAR2)  begin d.target_region = REGION_MISC2;  base = BASE_MISC2;  end
         else                      begin d.target_region = REGION_CHAR2;  base = BASE_CHAR2;  end
         d.decoded_address = a;
         // rom and the hole report offset zero
         if (d.target_region == REGION_ROM || d.target_region == REGION_UNMAPPED)
            d.region_offset = '0;
         else
            d.region_offset = OffsetWidth'(a - base);
         d.data_out = w.write_data;
         return d;
      endfunction

      function void note_write(write_type w);
         due_decodes.push_back(predict_decode(w));
      endfunction

      function void check_decode(decode_type got);
         decode_type want;
         if (due_decodes.size() == 0) begin
            $error("unexpected word: decoded_address %h", got.decoded_address);
            errors++;
            return;
         end
         want = due_decodes.pop_front();
         if (got.decoded_address !== want.decoded_address) begin
            $error("decoded_address: expected %h, actual %h",
                   want.decoded_address, got.decoded_address);
            errors++;
         end
         if (got.target_region !== want.target_region) begin
            $error("target_region: expected %0d, actual %0d",
                   want.target_region, got.target_region);
            errors++;
         end
         if (got.region_offset !== want.region_offset) begin
            $error("region_offset: expected %h, actual %h",
                   want.region_offset, got.region_offset);
            errors++;
         end
         if (got.data_out !== want.data_out) begin
            $error("data_out: expected %h, actual %h", want.data_out, got.data_out);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [ChipWidth-1:0] csr_write_data;

   ewad_req_if req_ch ();
   ewad_rsp_if rsp_ch ();

   decode_checker board = new();

   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   bit          pressure_on   = 1'b0;
   bit          pressure_done = 1'b0;
   int unsigned quiet_cycles  = 0;

   encrypted_write_address_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #HalfPeriod clock = ~clock;

   function automatic write_type random_write();
      write_type   w;
      int unsigned kind;
      logic [7:0]  page;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) page = 8'($urandom_range(0, 255));
      else page = EDGE_PAGES[$urandom_range(0, 15)];
      w.write_address = {page, 8'($urandom_range(0, 255))};
      w.write_data    = DataWidth'($urandom_range(0, 255));
      w.fetch_address = AddrWidth'($urandom_range(0, 65535));
      // mostly scrambled stores, the rest passes through
      if (kind < 75) begin
         w.fetch_valid  = 1'b1;
         w.fetch_opcode = OPC_STORE;
      end else if (kind < 85) begin
         w.fetch_valid  = 1'b0;
         w.fetch_opcode = OPC_STORE;
      end else begin
         w.fetch_valid  = (kind < 95);
         w.fetch_opcode = DataWidth'($urandom_range(0, 255));
      end
      return w;
   endfunction

   task automatic send_word(input write_type w);
      if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.write_address <= w.write_address;
      req_ch.write_data    <= w.write_data;
      req_ch.fetch_address <= w.fetch_address;
      req_ch.fetch_valid   <= w.fetch_valid;
      req_ch.fetch_opcode  <= w.fetch_opcode;
      do @(posedge clock); while (!req_ch.ready);
      board.note_write(w);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.due_decodes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_chip(input logic [ChipWidth-1:0] c);
      csr_write_enable <= 1'b1;
      csr_write_data   <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_chip(c);
   endtask

   task automatic send_directed();
      write_type w;
      foreach (REGION_EDGES[i]) begin
         w.write_address = REGION_EDGES[i];
         w.write_data    = i[0] ? 8'hFF : 8'h00;
         w.fetch_address = 16'hFFFF;
         w.fetch_valid   = 1'b0;
         w.fetch_opcode  = OPC_STORE;
         send_word(w);
      end
      // every permutation on one byte
      for (int s = 0; s < 4; s++) begin
         w.write_address = 16'hF0A5;
         w.write_data    = 8'hA5;
         w.fetch_address = 16'(s);
         w.fetch_valid   = 1'b1;
         w.fetch_opcode  = OPC_STORE;
         send_word(w);
      end
      // other opcode with a known fetch passes through
      w.write_address = 16'hF0A5;
      w.fetch_address = 16'h0000;
      w.fetch_opcode  = OPC_OTHER;
      send_word(w);
   endtask

   initial begin : stimulus
      logic [ChipWidth-1:0] c;
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = CHIP_NONE;
      req_ch.valid         = 1'b0;
      req_ch.write_address = '0;
      req_ch.write_data    = '0;
      req_ch.fetch_address = '0;
      req_ch.fetch_valid   = 1'b0;
      req_ch.fetch_opcode  = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < Phases; phase++) begin
         c = CHIP_PLAN[phase];
         if (phase == 9 || phase == 10) c = ChipWidth'($urandom_range(0, 7));
         write_chip(c);
         if (phase == Phases - 1) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: send_idle_pct = 0;
               1: send_idle_pct = 15;
               2: send_idle_pct = 40;
               default: send_idle_pct = 70;
            endcase
            case ($urandom_range(0, 3))
               0: take_idle_pct = 0;
               1: take_idle_pct = 15;
               2: take_idle_pct = 40;
               default: take_idle_pct = 70;
            endcase
         end
         if (phase == 1) send_directed();
         // fill the block while the receiver holds off
         if (phase == 4) begin
            send_idle_pct = 0;
            pressure_on   = 1'b1;
         end
         for (int n = 0; n < PhaseWords; n++) send_word(random_write());
         pressure_on = 1'b0;
         drain();
      end
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.due_decodes.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin : result_side
      int unsigned stall_left;
      int unsigned hold_left;
      decode_type  got;
      stall_left   = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.decoded_address = rsp_ch.decoded_address;
            got.target_region   = region_type'(rsp_ch.target_region);
            got.region_offset   = rsp_ch.region_offset;
            got.data_out        = rsp_ch.data_out;
            board.check_decode(got);
         end
         if (pressure_on && !pressure_done) begin
            hold_left     = HoldCycles;
            pressure_done = 1'b1;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (take_idle_pct != 0 && $urandom_range(1, 100) <= take_idle_pct) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

`default_nettype wire
